/* rtl/cia_pkg.sv */
// ----------------------------------------------------------------------------
// cia_pkg
// command, kind and error codes shared by the checked integer alu
// ----------------------------------------------------------------------------
package cia_pkg;

  typedef enum logic [3:0] {
    CMD_SADD = 4'd0,
    CMD_SSUB = 4'd1,
    CMD_SMUL = 4'd2,
    CMD_SDIV = 4'd3,
    CMD_SMOD = 4'd4,
    CMD_SNEG = 4'd5,
    CMD_UADD = 4'd6,
    CMD_USUB = 4'd7,
    CMD_UMUL = 4'd8,
    CMD_UDIV = 4'd9,
    CMD_UMOD = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SINT  = 2'd0,
    KIND_UINT  = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_OVF  = 3'd1,
    ERR_DIV0 = 3'd2,
    ERR_MOD0 = 3'd3,
    ERR_TYPE = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    OP_DONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2,
    OP_MOD  = 2'd3
  } op_t;

endpackage

/* rtl/cia_divider.sv */
// ----------------------------------------------------------------------------
// cia_divider
// unsigned restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module cia_divider #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  logic [W-1:0] rem [1:W];
  logic [W-1:0] quo [1:W];
  logic [W-1:0] dvs [1:W-1];

  for (genvar j = 0; j < W; j++) begin : g_step
    logic [W-1:0] rem_in;
    logic [W-1:0] quo_in;
    logic [W-1:0] dvs_in;
    logic [W:0]   shifted;
    logic [W:0]   diff;
    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = dividend;
      assign dvs_in = divisor;
    end else begin : g_later
      assign rem_in = rem[j];
      assign quo_in = quo[j];
      assign dvs_in = dvs[j];
    end
    assign shifted = {rem_in, quo_in[W-1]};
    assign diff    = shifted - {1'b0, dvs_in};
    always_ff @(posedge clk) begin
      if (!diff[W]) begin
        rem[j+1] <= diff[W-1:0];
        quo[j+1] <= {quo_in[W-2:0], 1'b1};
      end else begin
        rem[j+1] <= shifted[W-1:0];
        quo[j+1] <= {quo_in[W-2:0], 1'b0};
      end
    end
    if (j < W-1) begin : g_pass
      always_ff @(posedge clk) begin
        dvs[j+1] <= dvs_in;
      end
    end
  end

  assign quotient  = quo[W];
  assign remainder = rem[W];

endmodule

/* rtl/checked_int64_alu.sv */
// ----------------------------------------------------------------------------
// checked_int64_alu
// checked signed and unsigned add, subtract, multiply, divide, modulo, and signed negate
// ----------------------------------------------------------------------------
// path: operands pass an input register, the divider stages and an output
// register; the divider resolves one quotient bit per pipeline stage
// throughput: one transfer per cycle, busy is always low
// reset: clears the valid bits of every stage, so results in flight are dropped; no result is invented
// ----------------------------------------------------------------------------
module checked_int64_alu #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  input  logic [1:0]  a_kind,
  input  logic [1:0]  b_kind,
  output logic        done,
  output logic [63:0] value,
  output logic [2:0]  error
);
  import cia_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int LW = W / 2;
  localparam int HW = W - LW;
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONES = {W{1'b1}};

  typedef struct packed {
    logic         valid;
    op_t          op;
    logic         sgn;
    logic         neg;
    err_t         err;
    logic [W-1:0] val;
  } side_t;

  logic [W-1:0] a, b, neg_a, mag_a, mag_b;
  logic [W:0]   sum, dif;
  logic         sa, sb, s_ok, u_ok;
  side_t        d;
  logic [W-1:0] mx_d, my_d, dvd_d, dvs_d;

  assign busy  = 1'b0;
  assign a     = operand_a[W-1:0];
  assign b     = operand_b[W-1:0];
  assign sa    = a[W-1];
  assign sb    = b[W-1];
  assign neg_a = '0 - a;
  assign mag_a = sa ? neg_a : a;
  assign mag_b = sb ? ('0 - b) : b;
  assign sum   = {1'b0, a} + {1'b0, b};
  assign dif   = {1'b0, a} - {1'b0, b};
  assign s_ok  = (a_kind == KIND_SINT) && (b_kind == KIND_SINT);
  assign u_ok  = (a_kind == KIND_UINT) && (b_kind == KIND_UINT);

  always_comb begin
    d       = '0;
    d.valid = start && !busy && !rst;
    d.op    = OP_DONE;
    d.err   = ERR_NONE;
    mx_d    = a;
    my_d    = b;
    dvd_d   = a;
    dvs_d   = b;
    case (command)
      CMD_SADD: begin
        if (!s_ok) d.err = ERR_TYPE;
        else if (sa == sb && sum[W-1] != sa) d.err = ERR_OVF;
        else d.val = sum[W-1:0];
      end
      CMD_SSUB: begin
        if (!s_ok) d.err = ERR_TYPE;
        else if (sa != sb && dif[W-1] != sa) d.err = ERR_OVF;
        else d.val = dif[W-1:0];
      end
      CMD_SMUL: begin
        if (!s_ok) d.err = ERR_TYPE;
        else begin
          d.op  = OP_MUL;
          d.sgn = 1'b1;
          d.neg = sa ^ sb;
          mx_d  = mag_a;
          my_d  = mag_b;
        end
      end
      CMD_SDIV, CMD_SMOD: begin
        if (!s_ok) d.err = ERR_TYPE;
        else if (b == '0) d.err = (command == CMD_SDIV) ? ERR_DIV0 : ERR_MOD0;
        else if (a == SIGN && b == ONES) d.err = ERR_OVF;
        else begin
          d.op  = (command == CMD_SDIV) ? OP_DIV : OP_MOD;
          d.neg = (command == CMD_SDIV) ? (sa ^ sb) : sa;
          dvd_d = mag_a;
          dvs_d = mag_b;
        end
      end
      CMD_SNEG: begin
        if (a_kind != KIND_SINT) d.err = ERR_TYPE;
        else if (a == SIGN) d.err = ERR_OVF;
        else d.val = neg_a;
      end
      CMD_UADD: begin
        if (!u_ok) d.err = ERR_TYPE;
        else if (sum[W]) d.err = ERR_OVF;
        else d.val = sum[W-1:0];
      end
      CMD_USUB: begin
        if (!u_ok) d.err = ERR_TYPE;
        else if (dif[W]) d.err = ERR_OVF;
        else d.val = dif[W-1:0];
      end
      CMD_UMUL: begin
        if (!u_ok) d.err = ERR_TYPE;
        else d.op = OP_MUL;
      end
      CMD_UDIV, CMD_UMOD: begin
        if (!u_ok) d.err = ERR_TYPE;
        else if (b == '0) d.err = (command == CMD_UDIV) ? ERR_DIV0 : ERR_MOD0;
        else d.op = (command == CMD_UDIV) ? OP_DIV : OP_MOD;
      end
      default: d.err = ERR_TYPE;
    endcase
  end

  side_t        sd [0:W];
  logic [W-1:0] mx, my, dvd, dvs;

  always_ff @(posedge clk) begin
    sd[0] <= d;
    mx    <= mx_d;
    my    <= my_d;
    dvd   <= dvd_d;
    dvs   <= dvs_d;
  end

  // multiplier: partial products, then sum, then range check
  logic [2*LW-1:0]  pp_ll;
  logic [W-1:0]     pp_lh, pp_hl;
  logic [2*HW-1:0]  pp_hh;
  logic [2*W-1:0]   prod;
  logic [W-1:0]     lo, mul_val;
  logic             mul_ovf;

  always_ff @(posedge clk) begin
    pp_ll <= mx[LW-1:0] * my[LW-1:0];
    pp_lh <= mx[LW-1:0] * my[W-1:LW];
    pp_hl <= mx[W-1:LW] * my[LW-1:0];
    pp_hh <= mx[W-1:LW] * my[W-1:LW];
    prod  <= (2*W)'(pp_ll) + (((2*W)'(pp_lh) + (2*W)'(pp_hl)) << LW)
             + ((2*W)'(pp_hh) << (2*LW));
  end

  assign lo      = prod[W-1:0];
  assign mul_ovf = (prod[2*W-1:W] != '0)
                   || (sd[2].sgn && (lo > (sd[2].neg ? SIGN : SIGN - 1'b1)));
  assign mul_val = sd[2].neg ? ('0 - lo) : lo;

  for (genvar k = 0; k < W; k++) begin : g_side
    side_t sd_next;
    always_comb begin
      sd_next = sd[k];
      if (k == 2 && sd[k].op == OP_MUL) begin
        sd_next.op  = OP_DONE;
        sd_next.err = mul_ovf ? ERR_OVF : ERR_NONE;
        sd_next.val = mul_ovf ? '0 : mul_val;
      end
      if (rst) sd_next.valid = 1'b0;
    end
    always_ff @(posedge clk) begin
      sd[k+1] <= sd_next;
    end
  end

  logic [W-1:0] quo, rem, fin;

  cia_divider #(.W(W)) u_div (
    .clk       (clk),
    .dividend  (dvd),
    .divisor   (dvs),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    case (sd[W].op)
      OP_DIV:  fin = sd[W].neg ? ('0 - quo) : quo;
      OP_MOD:  fin = sd[W].neg ? ('0 - rem) : rem;
      default: fin = sd[W].val;
    endcase
    if (sd[W].err != ERR_NONE) fin = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sd[W].valid;
    end
    value <= 64'(fin);
    error <= sd[W].err;
  end

  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_reset_quiet: assert property (@(posedge clk) (!rst && $past(rst)) |-> !done)
    else $error("result strobe right after reset");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error != ERR_NONE) |-> value == 64'd0)
    else $error("nonzero value with error");
  a_bad_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && command > CMD_UMOD) |-> ##(W+2) (done && error == ERR_TYPE))
    else $error("unassigned command did not give a type error");

endmodule
